// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset.
`define ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/macw_pkg.sv -----
// ----------------------------------------------------------------------------
// macw_pkg
// Types and fixed widths of the moving-average crossover weight block.
// ----------------------------------------------------------------------------
package macw_pkg;

   localparam int PRICE_W  = 32;
   localparam int SEC_W    = 4;
   localparam int CFG_W    = 9;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W    = 40;
   localparam int SIG_W    = 6;
   localparam int TOT_W    = 10;
   localparam int WEIGHT_W = 18;
   localparam int DIV_NW   = 23;  // 2*|sig|*65536 + |total|
   localparam int DIV_DW   = 11;  // 2*|total|
   localparam int DIV_CW   = 5;

   localparam int SIG_MAX = 31;
   localparam int SIG_MIN = -32;
   localparam int TOT_MAX = 511;
   localparam int TOT_MIN = -512;
   localparam int MAX_EMIT = 16;

   localparam logic [CFG_W-1:0] LONG_RESET  = 9'd250;
   localparam logic [CFG_W-1:0] SHORT_RESET = 9'd50;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WINDOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WINDOW = 1'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_MUL,
      ST_POS,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/macw_channels.sv -----
// ----------------------------------------------------------------------------
// macw channels
// Price, weight and register-write channels of the crossover weight block.
// ----------------------------------------------------------------------------
interface macw_req_if;
   logic                          valid;
   logic                          ready;
   logic [macw_pkg::PRICE_W-1:0]  price;
   logic [macw_pkg::SEC_W-1:0]    security;
   logic                          tick_end;
   modport source (output valid, price, security, tick_end, input ready);
   modport sink   (input valid, price, security, tick_end, output ready);
endinterface

interface macw_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [macw_pkg::SEC_W-1:0]           asset;
   logic signed [macw_pkg::WEIGHT_W-1:0] weight;
   logic                                 zero_sum;
   logic                                 last;
   modport source (output valid, asset, weight, zero_sum, last, input ready);
   modport sink   (input valid, asset, weight, zero_sum, last, output ready);
endinterface

interface macw_csr_if;
   logic                           valid;
   logic                           ready;
   logic [macw_pkg::CSR_IDX_W-1:0] index;
   logic [macw_pkg::CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/moving_average_crossover_weights.sv -----
// ----------------------------------------------------------------------------
// moving_average_crossover_weights
// Per-security long/short moving-average crossover; emits normalized weights
// at the end of each tick.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          beat
//  req_ch   in   price, security, tick_end        one price
//  rsp_ch   out  asset, weight, zero_sum, last    one weight, per tick end
//  csr_ch   in   index, data                      one window register write
//
//  A price passes accept, ring read, sum update and write back, products and
//  compare before the next ready. A tick end then runs, per weight, load,
//  23 restoring divider steps and emit, or load and emit on a zero-sum
//  tick, NUM_SECURITIES (at most 16) weights per tick.
//  After reset and after each window write the history memory is swept to
//  zero, all NUM_SECURITIES*MAX_WINDOW entries, with req_ch.ready low.
//  A waiting weight beat holds while the next one is computed.
// ----------------------------------------------------------------------------
module moving_average_crossover_weights #(
   parameter int NUM_SECURITIES = 16,
   parameter int MAX_WINDOW     = 256
) (
   input  logic       clock,
   input  logic       reset,
   macw_req_if.sink   req_ch,
   macw_rsp_if.source rsp_ch,
   macw_csr_if.sink   csr_ch
);

   localparam int DEPTH = NUM_SECURITIES * MAX_WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int HW    = $clog2(MAX_WINDOW);
   localparam int LW    = $clog2(MAX_WINDOW + 1);
   localparam int IW    = (NUM_SECURITIES > 1) ? $clog2(NUM_SECURITIES) : 1;
   localparam int PW    = macw_pkg::SUM_W + LW;
   localparam int EMIT  = (NUM_SECURITIES < macw_pkg::MAX_EMIT) ?
                          NUM_SECURITIES : macw_pkg::MAX_EMIT;
   localparam logic [macw_pkg::SEC_W-1:0] LAST_K = macw_pkg::SEC_W'(EMIT - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [HW-1:0] LAST_HEAD = HW'(MAX_WINDOW - 1);

   macw_pkg::state_type state_ff, state_in;

   logic [macw_pkg::CFG_W-1:0]   long_win_ff, short_win_ff;
   logic [AW-1:0]                clr_addr_ff;
   logic [HW-1:0]                head_ff;
   logic                         started_ff;
   logic signed [macw_pkg::TOT_W-1:0] total_ff;
   logic [macw_pkg::SUM_W-1:0]   long_sum_ff  [NUM_SECURITIES];
   logic [macw_pkg::SUM_W-1:0]   short_sum_ff [NUM_SECURITIES];
   logic                         prev_pos_ff  [NUM_SECURITIES];
   logic signed [macw_pkg::SIG_W-1:0] sig_ff  [NUM_SECURITIES];

   logic [macw_pkg::PRICE_W-1:0] price_ff;
   logic [macw_pkg::SEC_W-1:0]   sec_ff;
   logic                         tick_end_ff;
   logic [PW-1:0]                prod_l_ff, prod_s_ff;

   logic [macw_pkg::SEC_W-1:0]   k_ff;
   logic [macw_pkg::DIV_NW-1:0]  num_ff, quo_ff;
   logic [macw_pkg::DIV_DW-1:0]  den_ff, rem_ff;
   logic [macw_pkg::DIV_CW-1:0]  cnt_ff;
   logic                         neg_ff, zero_ff;

   logic                         rsp_valid_ff;
   logic [macw_pkg::SEC_W-1:0]   rsp_asset_ff;
   logic signed [macw_pkg::WEIGHT_W-1:0] rsp_weight_ff;
   logic                         rsp_zero_ff, rsp_last_ff;

   // ---- window clamps and ring addresses ----
   int lw_int, sw_int, off_l, off_s, base_int;
   logic [LW-1:0] used_l, used_s;
   logic [IW-1:0] si, ki;
   logic          sec_ok;
   logic [AW-1:0] rd_addr_l, rd_addr_s, wr_addr;

   always_comb begin
      lw_int = int'(long_win_ff);
      if (lw_int < 2) lw_int = 2;
      if (lw_int > MAX_WINDOW) lw_int = MAX_WINDOW;
      sw_int = int'(short_win_ff);
      if (sw_int < 1) sw_int = 1;
      if (sw_int > lw_int) sw_int = lw_int;
      used_l = LW'(lw_int);
      used_s = LW'(sw_int);
      si       = IW'(sec_ff);
      ki       = IW'(k_ff);
      sec_ok   = int'(sec_ff) < NUM_SECURITIES;
      base_int = int'(si) * MAX_WINDOW;
      off_l = int'(head_ff) + MAX_WINDOW - lw_int;
      if (off_l >= MAX_WINDOW) off_l = off_l - MAX_WINDOW;
      off_s = int'(head_ff) + MAX_WINDOW - sw_int;
      if (off_s >= MAX_WINDOW) off_s = off_s - MAX_WINDOW;
      rd_addr_l = AW'(base_int + off_l);
      rd_addr_s = AW'(base_int + off_s);
      wr_addr   = AW'(base_int + int'(head_ff));
   end

   logic [macw_pkg::PRICE_W-1:0] old_l, old_s;
   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [macw_pkg::PRICE_W-1:0] ram_wdata;

   always_comb begin
      ram_we    = (state_ff == macw_pkg::ST_CLEAR) || (state_ff == macw_pkg::ST_UPDATE);
      ram_waddr = (state_ff == macw_pkg::ST_CLEAR) ? clr_addr_ff : wr_addr;
      ram_wdata = (state_ff == macw_pkg::ST_CLEAR) ? '0 : price_ff;
   end

   macw_hist_ram #(.DEPTH(DEPTH)) u_hist (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (rd_addr_l),
      .raddr_b (rd_addr_s),
      .rdata_a (old_l),
      .rdata_b (old_s)
   );

   // ---- per-price arithmetic ----
   logic [macw_pkg::SUM_W-1:0] new_long, new_short;
   logic                       pos;
   int                         sv_int, tot_int;

   always_comb begin
      new_long  = long_sum_ff[si] + macw_pkg::SUM_W'(price_ff) - macw_pkg::SUM_W'(old_l);
      new_short = short_sum_ff[si] + macw_pkg::SUM_W'(price_ff) - macw_pkg::SUM_W'(old_s);
      pos    = prod_l_ff > prod_s_ff;
      sv_int = int'(sig_ff[si]) + int'(pos) - int'(prev_pos_ff[si]);
      if (sv_int > macw_pkg::SIG_MAX) sv_int = macw_pkg::SIG_MAX;
      if (sv_int < macw_pkg::SIG_MIN) sv_int = macw_pkg::SIG_MIN;
      tot_int = int'(total_ff) + sv_int;
      if (tot_int > macw_pkg::TOT_MAX) tot_int = macw_pkg::TOT_MAX;
      if (tot_int < macw_pkg::TOT_MIN) tot_int = macw_pkg::TOT_MIN;
   end

   // ---- divider setup and step ----
   logic signed [macw_pkg::SIG_W-1:0] cur_sig;
   logic [macw_pkg::SIG_W-1:0]   abs_sig;
   logic [macw_pkg::TOT_W-1:0]   abs_tot;
   logic                         zero_now;
   logic [macw_pkg::DIV_DW:0]    shifted;
   logic                         q_bit;
   logic [macw_pkg::WEIGHT_W-1:0] wq, weight_val;
   logic                         out_free, csr_hit, emit_fire;

   always_comb begin
      cur_sig  = sig_ff[ki];
      abs_sig  = cur_sig[macw_pkg::SIG_W-1] ? macw_pkg::SIG_W'(-cur_sig) : cur_sig;
      abs_tot  = total_ff[macw_pkg::TOT_W-1] ? macw_pkg::TOT_W'(-total_ff) : total_ff;
      zero_now = !started_ff || (total_ff == '0);
      shifted  = {rem_ff, num_ff[macw_pkg::DIV_NW-1]};
      q_bit    = shifted >= {1'b0, den_ff};
      wq       = macw_pkg::WEIGHT_W'(quo_ff);
      weight_val = zero_ff ? '0 : (neg_ff ? -wq : wq);
      out_free = !rsp_valid_ff || rsp_ch.ready;
      emit_fire = (state_ff == macw_pkg::ST_EMIT) && out_free;
      csr_hit  = csr_ch.valid && ((csr_ch.index == macw_pkg::CSR_LONG_WINDOW) ||
                                  (csr_ch.index == macw_pkg::CSR_SHORT_WINDOW));
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= macw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         macw_pkg::ST_CLEAR:  if (clr_addr_ff == LAST_ADDR) state_in = macw_pkg::ST_IDLE;
         macw_pkg::ST_IDLE:   if (req_ch.valid) state_in = macw_pkg::ST_READ;
         macw_pkg::ST_READ: begin
            if (sec_ok) state_in = macw_pkg::ST_UPDATE;
            else if (tick_end_ff) state_in = macw_pkg::ST_LOAD;
            else state_in = macw_pkg::ST_IDLE;
         end
         macw_pkg::ST_UPDATE: state_in = macw_pkg::ST_MUL;
         macw_pkg::ST_MUL:    state_in = macw_pkg::ST_POS;
         macw_pkg::ST_POS:    state_in = tick_end_ff ? macw_pkg::ST_LOAD : macw_pkg::ST_IDLE;
         macw_pkg::ST_LOAD:   state_in = zero_now ? macw_pkg::ST_EMIT : macw_pkg::ST_DIV;
         macw_pkg::ST_DIV:    if (cnt_ff == '0) state_in = macw_pkg::ST_EMIT;
         macw_pkg::ST_EMIT: begin
            if (out_free) state_in = (k_ff == LAST_K) ? macw_pkg::ST_IDLE : macw_pkg::ST_LOAD;
         end
         default:             state_in = macw_pkg::ST_CLEAR;
      endcase
      // a window write restarts the history sweep
      if (csr_hit) state_in = macw_pkg::ST_CLEAR;
   end

   // ---- control state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         long_win_ff  <= macw_pkg::LONG_RESET;
         short_win_ff <= macw_pkg::SHORT_RESET;
         clr_addr_ff  <= '0;
         head_ff      <= '0;
         started_ff   <= 1'b0;
         total_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SECURITIES; i++) begin
            long_sum_ff[i]  <= '0;
            short_sum_ff[i] <= '0;
            prev_pos_ff[i]  <= 1'b0;
            sig_ff[i]       <= '0;
         end
      end else begin
         if (emit_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            macw_pkg::ST_CLEAR: if (!csr_hit) clr_addr_ff <= clr_addr_ff + 1'b1;
            macw_pkg::ST_UPDATE: begin
               long_sum_ff[si]  <= new_long;
               short_sum_ff[si] <= new_short;
            end
            macw_pkg::ST_POS: begin
               if (started_ff) begin
                  sig_ff[si] <= macw_pkg::SIG_W'(sv_int);
                  total_ff   <= macw_pkg::TOT_W'(tot_int);
               end
               prev_pos_ff[si] <= pos;
            end
            macw_pkg::ST_EMIT: begin
               if (out_free) begin
                  if (k_ff == LAST_K) begin
                     k_ff       <= '0;
                     started_ff <= 1'b1;
                     total_ff   <= '0;
                     head_ff    <= (head_ff == LAST_HEAD) ? '0 : head_ff + 1'b1;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
         if (csr_hit) begin
            if (csr_ch.index == macw_pkg::CSR_LONG_WINDOW) long_win_ff <= csr_ch.data;
            else short_win_ff <= csr_ch.data;
            clr_addr_ff <= '0;
            head_ff     <= '0;
            for (int i = 0; i < NUM_SECURITIES; i++) begin
               long_sum_ff[i]  <= '0;
               short_sum_ff[i] <= '0;
            end
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      case (state_ff)
         macw_pkg::ST_IDLE: begin
            price_ff    <= req_ch.price;
            sec_ff      <= req_ch.security;
            tick_end_ff <= req_ch.tick_end;
         end
         macw_pkg::ST_MUL: begin
            prod_l_ff <= PW'(long_sum_ff[si]) * PW'(used_s);
            prod_s_ff <= PW'(short_sum_ff[si]) * PW'(used_l);
         end
         macw_pkg::ST_LOAD: begin
            zero_ff <= zero_now;
            neg_ff  <= cur_sig[macw_pkg::SIG_W-1] != total_ff[macw_pkg::TOT_W-1];
            num_ff  <= macw_pkg::DIV_NW'({abs_sig, 17'b0}) + macw_pkg::DIV_NW'(abs_tot);
            den_ff  <= {abs_tot, 1'b0};
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= macw_pkg::DIV_CW'(macw_pkg::DIV_NW - 1);
         end
         macw_pkg::ST_DIV: begin
            rem_ff <= q_bit ? macw_pkg::DIV_DW'(shifted - {1'b0, den_ff})
                            : macw_pkg::DIV_DW'(shifted);
            quo_ff <= {quo_ff[macw_pkg::DIV_NW-2:0], q_bit};
            num_ff <= {num_ff[macw_pkg::DIV_NW-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         macw_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_asset_ff  <= k_ff;
               rsp_weight_ff <= weight_val;
               rsp_zero_ff   <= zero_ff;
               rsp_last_ff   <= k_ff == LAST_K;
            end
         end
         default: ;
      endcase
   end

   assign req_ch.ready    = state_ff == macw_pkg::ST_IDLE;
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.asset    = rsp_asset_ff;
   assign rsp_ch.weight   = rsp_weight_ff;
   assign rsp_ch.zero_sum = rsp_zero_ff;
   assign rsp_ch.last     = rsp_last_ff;

endmodule

// ----- rtl/macw_hist_ram.sv -----
// ----------------------------------------------------------------------------
// macw_hist_ram
// Price history memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module macw_hist_ram #(
   parameter int DEPTH = 4096
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(DEPTH)-1:0]     waddr,
   input  logic [macw_pkg::PRICE_W-1:0] wdata,
   input  logic [$clog2(DEPTH)-1:0]     raddr_a,
   input  logic [$clog2(DEPTH)-1:0]     raddr_b,
   output logic [macw_pkg::PRICE_W-1:0] rdata_a,
   output logic [macw_pkg::PRICE_W-1:0] rdata_b
);

   logic [macw_pkg::PRICE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// ----- rtl/macw_checker.sv -----
// ----------------------------------------------------------------------------
// macw_checker
// Port-level checks on the crossover weight block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module macw_checker #(
   parameter int NUM_SECURITIES = 16
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [macw_pkg::SEC_W-1:0]           rsp_asset,
   input logic signed [macw_pkg::WEIGHT_W-1:0] rsp_weight,
   input logic                                 rsp_zero_sum,
   input logic                                 rsp_last
);

   localparam int EMIT = (NUM_SECURITIES < macw_pkg::MAX_EMIT) ?
                         NUM_SECURITIES : macw_pkg::MAX_EMIT;
   localparam logic [macw_pkg::SEC_W-1:0] LAST_ASSET = macw_pkg::SEC_W'(EMIT - 1);

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_weight) && $stable(rsp_asset), "stalled weight beat changed")
   `ASSERT_IMP(a_zero_weight, rsp_valid && rsp_zero_sum, rsp_weight == '0, "zero sum beat with nonzero weight")
   `ASSERT_IMP(a_last_asset, rsp_valid && rsp_last, rsp_asset == LAST_ASSET, "last beat not on final security")
   `ASSERT_ALWAYS_NEXT(a_sweep_after_reset, reset, !req_ready, "price taken during history sweep")

endmodule

bind moving_average_crossover_weights macw_checker #(
   .NUM_SECURITIES (NUM_SECURITIES)
) u_macw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_asset    (rsp_ch.asset),
   .rsp_weight   (rsp_ch.weight),
   .rsp_zero_sum (rsp_ch.zero_sum),
   .rsp_last     (rsp_ch.last)
);
